// ===== sv/kped_pkg.sv =====
`timescale 1ns / 1ps

package kped_pkg;

  // Key field and state widths
  localparam int unsigned MaxKeys    = 8;
  localparam int unsigned KeyIdxW    = 3;
  localparam int unsigned TickW      = 16;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;

  // Register reset values
  localparam logic             PressedLevelRst = 1'b0;
  localparam logic [TickW-1:0] ClickMinRst     = 16'd5;
  localparam logic [TickW-1:0] LongPressRst    = 16'd300;
  localparam logic [TickW-1:0] PowerHoldRst    = 16'd400;
  localparam logic [TickW-1:0] TalkHoldRst     = 16'd20;
  localparam logic [KeyIdxW-1:0] TalkIdxRst    = 3'd0;
  localparam logic [KeyIdxW-1:0] PowerIdxRst   = 3'd1;

  // Register map, word index
  typedef enum logic [2:0] {
    RegPressedLevel = 3'd0,
    RegClickMin     = 3'd1,
    RegLongPress    = 3'd2,
    RegPowerHold    = 3'd3,
    RegTalkHold     = 3'd4,
    RegTalkIdx      = 3'd5,
    RegPowerIdx     = 3'd6
  } reg_idx_e;

  // Per-key machine
  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPressed = 2'd1,
    PhWait    = 2'd2
  } key_phase_e;

  // Detected event codes
  typedef enum logic [1:0] {
    EvClick    = 2'd0,
    EvLong     = 2'd1,
    EvHold     = 2'd2,
    EvReleased = 2'd3
  } ev_code_e;

  typedef struct packed {
    logic               pressed_level;
    logic [TickW-1:0]   click_min;
    logic [TickW-1:0]   long_press;
    logic [TickW-1:0]   power_hold;
    logic [TickW-1:0]   talk_hold;
    logic [KeyIdxW-1:0] talk_idx;
    logic [KeyIdxW-1:0] power_idx;
  } kped_cfg_t;

  // One record per input item that gives results
  typedef struct packed {
    logic                      inject;
    logic [KeyIdxW-1:0]        inj_key;
    logic [CodeW-1:0]          inj_code;
    logic [MaxKeys-1:0]        mask;
    logic [MaxKeys-1:0][1:0]   codes;
  } kped_rec_t;

endpackage

// ===== sv/kped_front.sv =====
`timescale 1ns / 1ps

module kped_front #(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kped_pkg::kped_cfg_t               cfg_i,
  input  logic                              take_i,
  input  logic                              mode_i,
  input  logic [kped_pkg::MaxKeys-1:0]      levels_i,
  input  logic [kped_pkg::KeyIdxW-1:0]      inject_key_i,
  input  logic [kped_pkg::CodeW-1:0]        inject_event_i,
  output logic                              rec_valid_o,
  output kped_pkg::kped_rec_t               rec_o
);

  localparam int unsigned ScanKeys =
    (KEY_COUNT < kped_pkg::MaxKeys) ? KEY_COUNT : kped_pkg::MaxKeys;

  logic                                   scan_take;
  logic [kped_pkg::MaxKeys-1:0]           hit;
  logic [kped_pkg::MaxKeys-1:0][1:0]      code;

  assign scan_take = take_i && !mode_i;

  // One lane per scanned key
  for (genvar g = 0; g < kped_pkg::MaxKeys; g++) begin : g_lane
    if (g < ScanKeys) begin : g_key
      localparam logic [kped_pkg::KeyIdxW-1:0] KeyIdx = kped_pkg::KeyIdxW'(g);

      kped_pkg::key_phase_e           phase_q, phase_d;
      logic [kped_pkg::TickW-1:0]     cnt_q, cnt_d, cnt_inc;
      logic                           down, is_talk, is_power, talk_hit, fire;
      kped_pkg::ev_code_e             fire_code, ev;
      logic                           ev_hit;

      assign down     = (levels_i[g] == cfg_i.pressed_level);
      assign is_talk  = (KeyIdx == cfg_i.talk_idx);
      assign is_power = (KeyIdx == cfg_i.power_idx);
      // saturating count
      assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + kped_pkg::TickW'(1);
      assign talk_hit = is_talk && (cnt_inc >= cfg_i.talk_hold);
      assign fire     = talk_hit || (is_power ? (cnt_inc >= cfg_i.power_hold)
                                              : (cnt_inc >= cfg_i.long_press));
      assign fire_code = (talk_hit || is_power) ? kped_pkg::EvHold : kped_pkg::EvLong;

      // next state
      always_comb begin
        phase_d = phase_q;
        cnt_d   = cnt_q;
        unique case (phase_q)
          kped_pkg::PhIdle: begin
            if (down) begin
              phase_d = kped_pkg::PhPressed;
              cnt_d   = '0;
            end
          end
          kped_pkg::PhPressed: begin
            if (down) begin
              cnt_d = cnt_inc;
              if (fire) begin
                phase_d = kped_pkg::PhWait;
                cnt_d   = '0;
              end
            end else begin
              phase_d = kped_pkg::PhIdle;
              cnt_d   = '0;
            end
          end
          kped_pkg::PhWait: begin
            if (!down) begin
              phase_d = kped_pkg::PhIdle;
              cnt_d   = '0;
            end
          end
          default: begin
            phase_d = kped_pkg::PhIdle;
            cnt_d   = '0;
          end
        endcase
      end

      // event out of this key
      always_comb begin
        ev_hit = 1'b0;
        ev     = kped_pkg::EvClick;
        unique case (phase_q)
          kped_pkg::PhPressed: begin
            if (down) begin
              ev_hit = fire;
              ev     = fire_code;
            end else begin
              ev_hit = (cnt_q >= cfg_i.click_min);
              ev     = kped_pkg::EvClick;
            end
          end
          kped_pkg::PhWait: begin
            ev_hit = !down && is_talk;
            ev     = kped_pkg::EvReleased;
          end
          default: begin
            ev_hit = 1'b0;
          end
        endcase
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          phase_q <= kped_pkg::PhIdle;
          cnt_q   <= '0;
        end else if (scan_take) begin
          phase_q <= phase_d;
          cnt_q   <= cnt_d;
        end
      end

      assign hit[g]  = ev_hit;
      assign code[g] = ev;
    end else begin : g_none
      assign hit[g]  = 1'b0;
      assign code[g] = kped_pkg::EvClick;
    end
  end

  // Record towards the queue; quiet ticks send nothing
  always_comb begin
    rec_o.inject   = mode_i;
    rec_o.inj_key  = inject_key_i;
    rec_o.inj_code = inject_event_i;
    rec_o.mask     = mode_i ? '0 : hit;
    rec_o.codes    = code;
  end

  assign rec_valid_o = take_i && (mode_i || (|hit));

endmodule

// ===== sv/kped_queue.sv =====
`timescale 1ns / 1ps

module kped_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  kped_pkg::kped_rec_t  wr_data_i,
  input  logic                 rd_i,
  output kped_pkg::kped_rec_t  rd_data_o,
  output logic                 valid_o,
  output logic                 full_o
);

  localparam int unsigned PtrW = (kped_pkg::QueueDepth > 1) ? $clog2(kped_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(kped_pkg::QueueDepth + 1);

  kped_pkg::kped_rec_t slot_q [kped_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == CntW'(kped_pkg::QueueDepth));
  assign valid_o   = (count_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(kped_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(kped_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/kped_back.sv =====
`timescale 1ns / 1ps

module kped_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  input  kped_pkg::kped_rec_t           rec_i,
  output logic                          rec_take_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [kped_pkg::KeyIdxW-1:0]  event_key_o,
  output logic [kped_pkg::CodeW-1:0]    event_code_o,
  output logic                          last_o
);

  kped_pkg::kped_rec_t                  cur_q;
  logic                                 cur_valid_q;
  logic                                 out_valid_q;
  logic [kped_pkg::KeyIdxW-1:0]         key_q;
  logic [kped_pkg::CodeW-1:0]           code_q;
  logic                                 last_q;

  logic [kped_pkg::KeyIdxW-1:0]         sel;
  logic [kped_pkg::MaxKeys-1:0]         sel_bit, rest;
  logic                                 is_last, emit, done, load, beat_out;

  // lowest pending key of the current record
  always_comb begin
    sel = '0;
    for (int i = kped_pkg::MaxKeys - 1; i >= 0; i--) begin
      if (cur_q.mask[i]) begin
        sel = kped_pkg::KeyIdxW'(i);
      end
    end
  end

  assign sel_bit  = kped_pkg::MaxKeys'(1) << sel;
  assign rest     = cur_q.mask & ~sel_bit;
  assign is_last  = cur_q.inject || (rest == '0);
  assign beat_out = pop_i && out_valid_q;
  assign emit     = cur_valid_q && (!out_valid_q || beat_out);
  assign done     = emit && is_last;
  assign load     = (!cur_valid_q || done) && rec_valid_i;
  assign rec_take_o = load;

  // current record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
    end else if (done) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= rec_i;
    end else if (emit) begin
      cur_q.mask <= rest;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (beat_out) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      key_q  <= cur_q.inject ? cur_q.inj_key : sel;
      code_q <= cur_q.inject ? cur_q.inj_code : {1'b0, cur_q.codes[sel]};
      last_q <= is_last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign event_key_o  = key_q;
  assign event_code_o = code_q;
  assign last_o       = last_q;

endmodule

// ===== sv/key_press_event_detector_core.sv =====
`timescale 1ns / 1ps

// Channel    Handshake            Beat
// input      push / full          mode_i, levels_i, inject_key_i, inject_event_i
// result     pop / empty          event_key_o, event_code_o, last_o
// config     psel/penable/pready  paddr (word index in bits 4:2), pwdata, prdata
//
// One input item is taken per cycle while the record queue (two entries) has room.
// A scan tick with n events (0 to 8) gives the serialiser n event beats; an inject
// item, one. The serialiser, one event per cycle unless stalled, sets the rate.
// Reset clears every key to idle with a zero count and loads register defaults.
// A held result stalls the serialiser; the queue then fills and full rises.

module key_press_event_detector_core #(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kped_pkg::ApbAddrW-1:0]     paddr,
  input  logic [kped_pkg::ApbDataW-1:0]     pwdata,
  output logic [kped_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic                              mode_i,
  input  logic [kped_pkg::MaxKeys-1:0]      levels_i,
  input  logic [kped_pkg::KeyIdxW-1:0]      inject_key_i,
  input  logic [kped_pkg::CodeW-1:0]        inject_event_i,
  input  logic                              pop,
  output logic                              empty,
  output logic [kped_pkg::KeyIdxW-1:0]      event_key_o,
  output logic [kped_pkg::CodeW-1:0]        event_code_o,
  output logic                              last_o
);

  kped_pkg::kped_cfg_t  cfg_q;
  kped_pkg::kped_rec_t  front_rec, queue_rec;
  kped_pkg::reg_idx_e   reg_idx;
  logic                 cfg_wr, take, front_valid, queue_valid, queue_take;

  assign pready  = 1'b1;
  assign reg_idx = kped_pkg::reg_idx_e'(paddr[kped_pkg::ApbAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressed_level <= kped_pkg::PressedLevelRst;
      cfg_q.click_min     <= kped_pkg::ClickMinRst;
      cfg_q.long_press    <= kped_pkg::LongPressRst;
      cfg_q.power_hold    <= kped_pkg::PowerHoldRst;
      cfg_q.talk_hold     <= kped_pkg::TalkHoldRst;
      cfg_q.talk_idx      <= kped_pkg::TalkIdxRst;
      cfg_q.power_idx     <= kped_pkg::PowerIdxRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kped_pkg::RegPressedLevel: cfg_q.pressed_level <= pwdata[0];
        kped_pkg::RegClickMin:     cfg_q.click_min     <= pwdata[kped_pkg::TickW-1:0];
        kped_pkg::RegLongPress:    cfg_q.long_press    <= pwdata[kped_pkg::TickW-1:0];
        kped_pkg::RegPowerHold:    cfg_q.power_hold    <= pwdata[kped_pkg::TickW-1:0];
        kped_pkg::RegTalkHold:     cfg_q.talk_hold     <= pwdata[kped_pkg::TickW-1:0];
        kped_pkg::RegTalkIdx:      cfg_q.talk_idx      <= pwdata[kped_pkg::KeyIdxW-1:0];
        kped_pkg::RegPowerIdx:     cfg_q.power_idx     <= pwdata[kped_pkg::KeyIdxW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      kped_pkg::RegPressedLevel: prdata = kped_pkg::ApbDataW'(cfg_q.pressed_level);
      kped_pkg::RegClickMin:     prdata = kped_pkg::ApbDataW'(cfg_q.click_min);
      kped_pkg::RegLongPress:    prdata = kped_pkg::ApbDataW'(cfg_q.long_press);
      kped_pkg::RegPowerHold:    prdata = kped_pkg::ApbDataW'(cfg_q.power_hold);
      kped_pkg::RegTalkHold:     prdata = kped_pkg::ApbDataW'(cfg_q.talk_hold);
      kped_pkg::RegTalkIdx:      prdata = kped_pkg::ApbDataW'(cfg_q.talk_idx);
      kped_pkg::RegPowerIdx:     prdata = kped_pkg::ApbDataW'(cfg_q.power_idx);
      default:                   prdata = '0;
    endcase
  end

  assign take = push && !full;

  kped_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .take_i         (take),
    .mode_i         (mode_i),
    .levels_i       (levels_i),
    .inject_key_i   (inject_key_i),
    .inject_event_i (inject_event_i),
    .rec_valid_o    (front_valid),
    .rec_o          (front_rec)
  );

  kped_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_rec),
    .rd_i      (queue_take),
    .rd_data_o (queue_rec),
    .valid_o   (queue_valid),
    .full_o    (full)
  );

  kped_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (queue_valid),
    .rec_i        (queue_rec),
    .rec_take_o   (queue_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .event_key_o  (event_key_o),
    .event_code_o (event_code_o),
    .last_o       (last_o)
  );

endmodule

// ===== sv/kped_checker.sv =====
`timescale 1ns / 1ps

module kped_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pop,
  input logic                          empty,
  input logic                          pready,
  input logic [kped_pkg::KeyIdxW-1:0]  event_key_o,
  input logic [kped_pkg::CodeW-1:0]    event_code_o,
  input logic                          last_o
);

  // a held result does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(event_key_o) && $stable(event_code_o)
                          && $stable(last_o)))
    else $error("result changed while stalled");

  // the rest of a tick is already buffered: no gap after a non-final beat
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a tick's events");

  // events of one tick come out in rising key order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> (event_key_o > $past(event_key_o)))
    else $error("events out of key order");

  // the register port never waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind key_press_event_detector_core kped_checker u_checker (.*);

// ===== tb/key_press_event_detector_core_tb.sv =====
`timescale 1ns / 1ps

module key_press_event_detector_core_tb;
  import kped_pkg::*;

  localparam int KeyCount   = 8;
  localparam int ScanKeys   = (KeyCount < 8) ? KeyCount : 8;
  localparam int StallLimit = 4000;
  localparam int SettleWait = 16;

  // One queued input beat
  typedef struct {
    logic               mode;
    logic [7:0]         levels;
    logic [KeyIdxW-1:0] inj_key;
    logic [CodeW-1:0]   inj_code;
    logic               drain_first;
  } key_scan_t;

  // One predicted event beat
  typedef struct packed {
    logic [KeyIdxW-1:0] key;
    logic [CodeW-1:0]   code;
    logic               fin;
  } key_event_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ApbAddrW-1:0] paddr          = '0;
  logic [ApbDataW-1:0] pwdata         = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                push           = 1'b0;
  logic                full;
  logic                mode_i         = 1'b0;
  logic [MaxKeys-1:0]  levels_i       = '0;
  logic [KeyIdxW-1:0]  inject_key_i   = '0;
  logic [CodeW-1:0]    inject_event_i = '0;
  logic                pop            = 1'b0;
  logic                empty;
  logic [KeyIdxW-1:0]  event_key_o;
  logic [CodeW-1:0]    event_code_o;
  logic                last_o;

  key_scan_t  scan_backlog[$];
  key_event_t due_events[$];

  // Mirror of the block: registers and per-key machines
  kped_cfg_t  cfg_model;
  key_phase_e key_state[8];
  logic [TickW-1:0] held_ticks[8];

  // Stimulus shaping: wanted key level runs
  logic key_down[8];
  int   run_left[8];

  int  send_gap_pct = 0;
  int  recv_gap_pct = 0;
  bit  rst_done     = 1'b0;
  bit  in_beat      = 1'b0;
  bit  out_beat     = 1'b0;
  int  fail_count   = 0;
  int  quiet_cycles = 0;

  key_press_event_detector_core #(.KEY_COUNT(KeyCount)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .levels_i       (levels_i),
    .inject_key_i   (inject_key_i),
    .inject_event_i (inject_event_i),
    .pop            (pop),
    .empty          (empty),
    .event_key_o    (event_key_o),
    .event_code_o   (event_code_o),
    .last_o         (last_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the events one accepted input beat gives, lowest key first
  task automatic predict_key_events(input logic mode, input logic [7:0] levels,
                                    input logic [KeyIdxW-1:0] ikey,
                                    input logic [CodeW-1:0] icode);
    key_event_t batch[$];
    logic       down;
    if (mode) begin
      batch.push_back('{key: ikey, code: icode, fin: 1'b0});
    end else begin
      for (int k = 0; k < ScanKeys; k++) begin
        down = (levels[k] == cfg_model.pressed_level);
        case (key_state[k])
          PhIdle: begin
            if (down) begin
              key_state[k]  = PhPressed;
              held_ticks[k] = '0;
            end
          end
          PhPressed: begin
            if (down) begin
              if (held_ticks[k] != '1) held_ticks[k]++;
              if (k == cfg_model.talk_idx && held_ticks[k] >= cfg_model.talk_hold) begin
                key_state[k]  = PhWait;
                held_ticks[k] = '0;
                batch.push_back('{key: k[2:0], code: {1'b0, EvHold}, fin: 1'b0});
              end else if (k == cfg_model.power_idx) begin
                if (held_ticks[k] >= cfg_model.power_hold) begin
                  key_state[k]  = PhWait;
                  held_ticks[k] = '0;
                  batch.push_back('{key: k[2:0], code: {1'b0, EvHold}, fin: 1'b0});
                end
              end else if (held_ticks[k] >= cfg_model.long_press) begin
                key_state[k]  = PhWait;
                held_ticks[k] = '0;
                batch.push_back('{key: k[2:0], code: {1'b0, EvLong}, fin: 1'b0});
              end
            end else begin
              if (held_ticks[k] >= cfg_model.click_min)
                batch.push_back('{key: k[2:0], code: {1'b0, EvClick}, fin: 1'b0});
              key_state[k]  = PhIdle;
              held_ticks[k] = '0;
            end
          end
          PhWait: begin
            if (!down) begin
              key_state[k]  = PhIdle;
              held_ticks[k] = '0;
              if (k == cfg_model.talk_idx)
                batch.push_back('{key: k[2:0], code: {1'b0, EvReleased}, fin: 1'b0});
            end
          end
          default: begin
            key_state[k]  = PhIdle;
            held_ticks[k] = '0;
          end
        endcase
      end
    end
    if (batch.size() != 0) batch[batch.size()-1].fin = 1'b1;
    foreach (batch[i]) due_events.push_back(batch[i]);
  endtask

  // Input side: present queued beats, hold until taken; result side pops at random
  always @(negedge clk_i) begin : drive_beats
    key_scan_t nxt;
    bit        hold_cur;
    bit        send;
    hold_cur = push && !in_beat;
    send     = 1'b0;
    if (!hold_cur && rst_done && scan_backlog.size() != 0 &&
        $urandom_range(99) >= send_gap_pct) begin
      // a marked beat waits until every outstanding event is out
      if (!scan_backlog[0].drain_first || due_events.size() == 0) send = 1'b1;
    end
    if (send) begin
      nxt = scan_backlog.pop_front();
      push           <= 1'b1;
      mode_i         <= nxt.mode;
      levels_i       <= nxt.levels;
      inject_key_i   <= nxt.inj_key;
      inject_event_i <= nxt.inj_code;
    end else if (!hold_cur) begin
      push <= 1'b0;
    end
    pop <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Beat monitor and event checker
  always @(posedge clk_i) begin : watch_beats
    key_event_t want;
    in_beat  = rst_ni && push && !full;
    out_beat = rst_ni && pop && !empty;
    if (in_beat) predict_key_events(mode_i, levels_i, inject_key_i, inject_event_i);
    if (out_beat) begin
      if (due_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected event beat: key %0d code %0d last %0b",
                   event_key_o, event_code_o, last_o);
      end else begin
        want = due_events.pop_front();
        if (event_key_o !== want.key || event_code_o !== want.code ||
            last_o !== want.fin) begin
          fail_count++;
          if (fail_count <= 10)
            $display("event mismatch: expected key %0d code %0d last %0b,",
                     want.key, want.code, want.fin,
                     " got key %0d code %0d last %0b",
                     event_key_o, event_code_o, last_o);
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin : watchdog
    if (rst_done) begin
      if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("** key_press_event_detector_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // Register write: setup then access, mirror updated once it lands
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegPressedLevel: cfg_model.pressed_level = val[0];
      RegClickMin:     cfg_model.click_min     = val[15:0];
      RegLongPress:    cfg_model.long_press    = val[15:0];
      RegPowerHold:    cfg_model.power_hold    = val[15:0];
      RegTalkHold:     cfg_model.talk_hold     = val[15:0];
      RegTalkIdx:      cfg_model.talk_idx      = val[2:0];
      RegPowerIdx:     cfg_model.power_idx     = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic pl, input logic [15:0] clk_min,
                            input logic [15:0] lng, input logic [15:0] pwr,
                            input logic [15:0] tlk, input logic [2:0] tidx,
                            input logic [2:0] pidx);
    reg_write(RegPressedLevel, {31'd0, pl});
    reg_write(RegClickMin,     {16'd0, clk_min});
    reg_write(RegLongPress,    {16'd0, lng});
    reg_write(RegPowerHold,    {16'd0, pwr});
    reg_write(RegTalkHold,     {16'd0, tlk});
    reg_write(RegTalkIdx,      {29'd0, tidx});
    reg_write(RegPowerIdx,     {29'd0, pidx});
  endtask

  task automatic add_item(input logic mode, input logic [7:0] levels,
                          input logic [2:0] ikey, input logic [2:0] icode);
    scan_backlog.push_back('{mode: mode, levels: levels, inj_key: ikey,
                             inj_code: icode, drain_first: 1'b0});
  endtask

  // Wait until the block has gone quiet, then let it settle
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (scan_backlog.size() != 0 || push || due_events.size() != 0);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Mostly well-formed press / release runs straddling the thresholds,
  // some injects and some noise scans
  task automatic queue_random(input int count);
    key_scan_t it;
    int        r;
    int        thr;
    int        cmin;
    cmin = (cfg_model.click_min > 60) ? 60 : int'(cfg_model.click_min);
    for (int i = 0; i < count; i++) begin
      it.inj_key     = KeyIdxW'($urandom);
      it.inj_code    = CodeW'($urandom);
      it.levels      = 8'($urandom);
      it.drain_first = (i == count / 2);
      r = $urandom_range(99);
      it.mode = (r < 10);
      if (r >= 18) begin
        for (int k = 0; k < 8; k++) begin
          if (run_left[k] == 0) begin
            key_down[k] = !key_down[k];
            thr = int'(cfg_model.long_press);
            if (k == cfg_model.power_idx) thr = int'(cfg_model.power_hold);
            if (k == cfg_model.talk_idx && int'(cfg_model.talk_hold) < thr)
              thr = int'(cfg_model.talk_hold);
            if (thr > 60) thr = 60;
            if (!key_down[k]) begin
              run_left[k] = $urandom_range(4, 1);
            end else begin
              case ($urandom_range(3))
                0:       run_left[k] = $urandom_range(cmin + 1, 1);
                1:       run_left[k] = $urandom_range(thr + 2, thr);
                2:       run_left[k] = $urandom_range(2 * thr + 2, 1);
                default: run_left[k] = $urandom_range(cmin + 2, (cmin < 1) ? 1 : cmin);
              endcase
            end
          end
          run_left[k]--;
          it.levels[k] = key_down[k] ? cfg_model.pressed_level : !cfg_model.pressed_level;
        end
      end
      scan_backlog.push_back(it);
    end
  endtask

  initial begin : main_seq
    cfg_model = '{pressed_level: PressedLevelRst, click_min: ClickMinRst,
                  long_press: LongPressRst, power_hold: PowerHoldRst,
                  talk_hold: TalkHoldRst, talk_idx: TalkIdxRst, power_idx: PowerIdxRst};
    for (int k = 0; k < 8; k++) begin
      key_state[k]  = PhIdle;
      held_ticks[k] = '0;
      key_down[k]   = 1'b0;
      run_left[k]   = 0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni   = 1'b1;
    rst_done = 1'b1;

    // Sender idles lightly, receiver heavily
    send_gap_pct = 15;
    recv_gap_pct = 70;

    // Directed, reset settings (level 0 is pressed): injects at the code and
    // key extremes, an idle tick, a talk key hold, a release burst with
    // every key and a press too short for a click
    add_item(1'b1, 8'h5A, 3'd7, 3'd7);
    add_item(1'b1, 8'hA5, 3'd0, 3'd0);
    add_item(1'b1, 8'h00, 3'd5, 3'd4);
    add_item(1'b0, 8'hFF, 3'd7, 3'd7);
    repeat (21) add_item(1'b0, 8'h00, KeyIdxW'($urandom), CodeW'($urandom));
    add_item(1'b0, 8'hFF, 3'd0, 3'd0);
    add_item(1'b0, 8'h00, 3'd2, 3'd5);
    add_item(1'b0, 8'hFF, 3'd6, 3'd1);
    wait_quiet();

    // Small thresholds, active-high pins
    set_config(1'b1, 16'd2, 16'd6, 16'd9, 16'd4, 3'd3, 3'd5);
    queue_random(95);
    wait_quiet();

    // Sender idles heavily, receiver lightly; minimum thresholds and a
    // shared talk / power key where the talk test is checked first
    send_gap_pct = 70;
    recv_gap_pct = 15;
    set_config(1'b0, 16'd0, 16'd1, 16'd1, 16'd6, 3'd7, 3'd7);
    queue_random(95);
    wait_quiet();

    // No idling from here on; maximum thresholds, every key held for a
    // stretch and released without any event
    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd2, 3'd0);
    repeat (17) add_item(1'b0, 8'hFF, KeyIdxW'($urandom), CodeW'($urandom));
    add_item(1'b0, 8'h00, 3'd1, 3'd6);
    add_item(1'b0, 8'hFF, 3'd4, 3'd3);
    add_item(1'b0, 8'h00, 3'd7, 3'd2);
    wait_quiet();

    // Mid-range settings with the minimum talk threshold
    set_config(1'b0, 16'd3, 16'd12, 16'd20, 16'd1, 3'd4, 3'd6);
    queue_random(95);
    wait_quiet();

    fail_count += due_events.size();
    if (fail_count == 0) begin
      $display("** key_press_event_detector_core: PASSED **");
    end else begin
      $display("** key_press_event_detector_core: FAILED **");
    end
    $finish;
  end

endmodule
